// ===== rtl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/gcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcs_pkg
// Types and constants shared by the gripper claw sequencer modules.
// ----------------------------------------------------------------------------
package gcs_pkg;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_GRABBING  = 3'd1,
        ST_GRABBED   = 3'd2,
        ST_RELEASING = 3'd3,
        ST_LANDING   = 3'd4
    } claw_state_t;

    typedef enum logic [2:0] {
        REG_RC_THRESHOLD    = 3'd0,
        REG_GRAB_POS        = 3'd1,
        REG_RELEASE_POS     = 3'd2,
        REG_TRANSIT_POS     = 3'd3,
        REG_LANDING_POS     = 3'd4,
        REG_GRAB_TIMEOUT    = 3'd5,
        REG_RELEASE_TIMEOUT = 3'd6
    } cfg_index_t;

    localparam logic CMD_GRAB    = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [31:0] TIMEOUT_RESET = 32'd1000000;

    typedef struct packed {
        logic signed [15:0] rc_threshold;
        logic signed [15:0] grab_position;
        logic signed [15:0] release_position;
        logic signed [15:0] transit_position;
        logic signed [15:0] landing_position;
        logic [31:0]        grab_timeout_us;
        logic [31:0]        release_timeout_us;
    } cfg_t;

    typedef struct packed {
        logic [31:0]        now_us;
        logic signed [15:0] aux_value;
        logic               rc_signal_lost;
        logic               rc_update;
        logic               is_landed;
        logic               land_update;
    } tick_t;

    typedef struct packed {
        logic               last_of_run;
        logic signed [15:0] servo_position;
        logic               gripper_command;
    } result_t;

    typedef struct packed {
        logic    valid0;
        logic    valid1;
        result_t res0;
        result_t res1;
    } step_out_t;

endpackage
`default_nettype wire

// ===== rtl/gcs_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcs_step
// Claw state registers and the single-pass tick logic: landing handling
// followed by the rc-driven state machine, up to two results per tick.
// ----------------------------------------------------------------------------
module gcs_step (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    fire,
    input  gcs_pkg::tick_t         tick,
    input  gcs_pkg::cfg_t          cfg,
    output gcs_pkg::step_out_t     step
);

    gcs_pkg::claw_state_t claw_state_reg, claw_state_next;
    gcs_pkg::claw_state_t saved_state_reg, saved_state_next;
    logic                 landed_reg, landed_next;
    logic [31:0]          entry_time_reg, entry_time_next;

    logic                 land_hit;
    gcs_pkg::result_t     land_res;
    logic                 rc_hit;
    gcs_pkg::result_t     rc_res;
    gcs_pkg::claw_state_t mid_state;
    logic                 grab_req;
    logic [31:0]          elapsed;

    // landing stage
    always_comb
    begin
        land_hit         = 1'b0;
        land_res         = '0;
        mid_state        = claw_state_reg;
        saved_state_next = saved_state_reg;
        landed_next      = landed_reg;
        if (tick.land_update)
        begin
            if (tick.is_landed && !landed_reg)
            begin
                saved_state_next        = claw_state_reg;
                mid_state               = gcs_pkg::ST_LANDING;
                land_hit                = 1'b1;
                land_res.gripper_command = gcs_pkg::CMD_GRAB;
                land_res.servo_position  = cfg.landing_position;
            end
            else if (!tick.is_landed && landed_reg)
            begin
                mid_state = saved_state_reg;
                land_hit  = 1'b1;
                unique case (saved_state_reg)
                    gcs_pkg::ST_GRABBED:
                    begin
                        land_res.gripper_command = gcs_pkg::CMD_GRAB;
                        land_res.servo_position  = cfg.grab_position;
                    end
                    gcs_pkg::ST_GRABBING:
                    begin
                        land_res.gripper_command = gcs_pkg::CMD_GRAB;
                        land_res.servo_position  = cfg.transit_position;
                    end
                    gcs_pkg::ST_RELEASING:
                    begin
                        land_res.gripper_command = gcs_pkg::CMD_RELEASE;
                        land_res.servo_position  = cfg.transit_position;
                    end
                    default:
                    begin
                        land_res.gripper_command = gcs_pkg::CMD_RELEASE;
                        land_res.servo_position  = cfg.release_position;
                    end
                endcase
            end
            landed_next = tick.is_landed;
        end
    end

    // rc stage, only while airborne with a live sample
    always_comb
    begin
        grab_req        = tick.aux_value >= cfg.rc_threshold;
        elapsed         = tick.now_us - entry_time_reg;
        rc_hit          = 1'b0;
        rc_res          = '0;
        claw_state_next = mid_state;
        entry_time_next = entry_time_reg;
        if (!landed_next && tick.rc_update && !tick.rc_signal_lost)
        begin
            unique case (mid_state)
                gcs_pkg::ST_IDLE:
                begin
                    if (grab_req)
                    begin
                        claw_state_next        = gcs_pkg::ST_GRABBING;
                        entry_time_next        = tick.now_us;
                        rc_hit                 = 1'b1;
                        rc_res.gripper_command = gcs_pkg::CMD_GRAB;
                        rc_res.servo_position  = cfg.transit_position;
                    end
                end
                gcs_pkg::ST_GRABBING:
                begin
                    if (elapsed >= cfg.grab_timeout_us)
                    begin
                        claw_state_next        = gcs_pkg::ST_GRABBED;
                        rc_hit                 = 1'b1;
                        rc_res.gripper_command = gcs_pkg::CMD_GRAB;
                        rc_res.servo_position  = cfg.grab_position;
                    end
                end
                gcs_pkg::ST_GRABBED:
                begin
                    if (!grab_req)
                    begin
                        claw_state_next        = gcs_pkg::ST_RELEASING;
                        entry_time_next        = tick.now_us;
                        rc_hit                 = 1'b1;
                        rc_res.gripper_command = gcs_pkg::CMD_RELEASE;
                        rc_res.servo_position  = cfg.transit_position;
                    end
                end
                gcs_pkg::ST_RELEASING:
                begin
                    if (elapsed >= cfg.release_timeout_us)
                    begin
                        claw_state_next        = gcs_pkg::ST_IDLE;
                        rc_hit                 = 1'b1;
                        rc_res.gripper_command = gcs_pkg::CMD_RELEASE;
                        rc_res.servo_position  = cfg.release_position;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // landing result goes first when both fire
    always_comb
    begin
        step.valid0          = land_hit || rc_hit;
        step.valid1          = land_hit && rc_hit;
        step.res0            = land_hit ? land_res : rc_res;
        step.res0.last_of_run = !(land_hit && rc_hit);
        step.res1            = rc_res;
        step.res1.last_of_run = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            claw_state_reg  <= gcs_pkg::ST_IDLE;
            saved_state_reg <= gcs_pkg::ST_IDLE;
            landed_reg      <= 1'b0;
            entry_time_reg  <= '0;
        end
        else if (fire)
        begin
            claw_state_reg  <= claw_state_next;
            saved_state_reg <= saved_state_next;
            landed_reg      <= landed_next;
            entry_time_reg  <= entry_time_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/gripper_claw_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// flow: an item is registered on accept and processed once the output queue has room
// for two results; its results are then written to the queue and shown on m_tvalid
// throughput: one item per cycle while the queue has room for two results; the single
// result port drains the four-entry output queue, one entry per pop
// reset: claw idle, not landed, threshold and positions 0, timeouts 1000000 us
// ----------------------------------------------------------------------------
// gripper_claw_sequencer
// Gripper claw sequencer top level: input register, config registers,
// tick logic and output queue.
// ----------------------------------------------------------------------------
module gripper_claw_sequencer (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    // land_update, is_landed, rc_update, rc_signal_lost, aux_value[15:0],
    // now_us[31:0], zero fill
    input  wire  [55:0] s_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    // gripper_command, servo_position[15:0], zero fill
    output logic [23:0] m_tdata,
    output logic        m_tlast,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [2:0]  cfg_index,
    input  wire  [31:0] cfg_data
);

    gcs_pkg::cfg_t      cfg_reg;
    gcs_pkg::tick_t     tick_reg;
    logic               in_valid_reg;
    gcs_pkg::step_out_t step;
    logic               proc;

    gcs_pkg::result_t   fifo_mem [4];
    logic [1:0]         wr_ptr_reg, rd_ptr_reg;
    logic [2:0]         count_reg, count_next;
    logic               pop;
    logic [1:0]         n_push;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rc_threshold       <= '0;
            cfg_reg.grab_position      <= '0;
            cfg_reg.release_position   <= '0;
            cfg_reg.transit_position   <= '0;
            cfg_reg.landing_position   <= '0;
            cfg_reg.grab_timeout_us    <= gcs_pkg::TIMEOUT_RESET;
            cfg_reg.release_timeout_us <= gcs_pkg::TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                gcs_pkg::REG_RC_THRESHOLD:    cfg_reg.rc_threshold       <= cfg_data[15:0];
                gcs_pkg::REG_GRAB_POS:        cfg_reg.grab_position      <= cfg_data[15:0];
                gcs_pkg::REG_RELEASE_POS:     cfg_reg.release_position   <= cfg_data[15:0];
                gcs_pkg::REG_TRANSIT_POS:     cfg_reg.transit_position   <= cfg_data[15:0];
                gcs_pkg::REG_LANDING_POS:     cfg_reg.landing_position   <= cfg_data[15:0];
                gcs_pkg::REG_GRAB_TIMEOUT:    cfg_reg.grab_timeout_us    <= cfg_data;
                gcs_pkg::REG_RELEASE_TIMEOUT: cfg_reg.release_timeout_us <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // an item is processed once the queue has room for two results
    assign proc     = in_valid_reg && (count_reg <= 3'd2);
    assign s_tready = !in_valid_reg || proc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            tick_reg <= s_tdata[51:0];
        end
    end

    gcs_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (proc),
        .tick  (tick_reg),
        .cfg   (cfg_reg),
        .step  (step)
    );

    assign pop    = m_tvalid && m_tready;
    assign n_push = proc ? ({1'b0, step.valid0} + {1'b0, step.valid1}) : 2'd0;

    always_comb
    begin
        count_next = count_reg + {1'b0, n_push} - {2'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + n_push;
            rd_ptr_reg <= rd_ptr_reg + {1'b0, pop};
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && step.valid0)
        begin
            fifo_mem[wr_ptr_reg] <= step.res0;
        end
        if (proc && step.valid1)
        begin
            fifo_mem[wr_ptr_reg + 2'd1] <= step.res1;
        end
    end

    assign m_tvalid = (count_reg != 3'd0);
    assign m_tdata  = {7'b0, fifo_mem[rd_ptr_reg].servo_position,
                       fifo_mem[rd_ptr_reg].gripper_command};
    assign m_tlast  = fifo_mem[rd_ptr_reg].last_of_run;

endmodule
`default_nettype wire

// ===== rtl/gcs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// gcs_checker
// Port-level checks on the gripper claw sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module gcs_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [23:0] m_tdata,
    input wire        m_tlast,
    input wire        cfg_ready
);

    // a held result keeps its payload
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // input only stalls while results are backed up
    `ASSERT_IMPLY(a_stall_cause, clk, rst_n, !s_tready, m_tvalid)

    // the second result of a tick is queued with the first
    `ASSERT_NEXT(a_run_tail, clk, rst_n, m_tvalid && m_tready && !m_tlast, m_tvalid)

    // configuration writes are never refused
    `ASSERT_IMPLY(a_cfg_open, clk, rst_n, 1'b1, cfg_ready)

endmodule

bind gripper_claw_sequencer gcs_checker u_gcs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_ready (cfg_ready)
);
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the gripper claw sequencer. Directed ticks cover reset defaults,
// register extremes, timeouts, touchdown, takeoff and a long output hold; random phases
// then run well-formed tick streams under several settings, with stalls on both buses.
// Every command is checked against a behavioural model kept in the bench.
// ----------------------------------------------------------------------------
module testbench;

    localparam int STALL_LIMIT  = 2000;
    localparam int QUIET_CYCLES = 6;
    localparam int PHASE_TICKS  = 150;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid;
    logic                s_tready;
    logic [55:0]         s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [23:0]         m_tdata;
    logic                m_tlast;
    logic                cfg_valid;
    logic                cfg_ready;
    gcs_pkg::cfg_index_t cfg_index;
    logic [31:0]         cfg_data;

    // model state and register copy
    gcs_pkg::claw_state_t claw_now;
    gcs_pkg::claw_state_t claw_saved;
    logic                 landed_now;
    logic [31:0]          hold_start_us;
    gcs_pkg::cfg_t        shadow_cfg;
    gcs_pkg::result_t     pending_cmds[$];

    logic [31:0] clock_us;
    int          mismatches = 0;
    int          tx_max_gap = 13;
    int          rx_max_gap = 13;
    int          rx_hold_cycles = 0;
    int          quiet_cycles = 0;

    gripper_claw_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic gcs_pkg::result_t make_cmd(input logic cmd, input logic [15:0] pos);
        gcs_pkg::result_t r;
        r.gripper_command = cmd;
        r.servo_position  = pos;
        r.last_of_run     = 1'b0;
        return r;
    endfunction

    function automatic gcs_pkg::tick_t tick_of(input logic lu, input logic il,
                                               input logic ru, input logic lost,
                                               input logic [15:0] aux,
                                               input logic [31:0] now);
        gcs_pkg::tick_t t;
        t.land_update    = lu;
        t.is_landed      = il;
        t.rc_update      = ru;
        t.rc_signal_lost = lost;
        t.aux_value      = aux;
        t.now_us         = now;
        return t;
    endfunction

    // works out the commands one tick causes and queues them
    task automatic advance_claw(input gcs_pkg::tick_t t);
        gcs_pkg::result_t outs[2];
        int               n;
        logic             grab_req;
        logic [31:0]      elapsed;
        n = 0;
        if (t.land_update)
        begin
            if (t.is_landed && !landed_now)
            begin
                claw_saved = claw_now;
                claw_now   = gcs_pkg::ST_LANDING;
                outs[n]    = make_cmd(gcs_pkg::CMD_GRAB, shadow_cfg.landing_position);
                n++;
            end
            else if (!t.is_landed && landed_now)
            begin
                claw_now = claw_saved;
                case (claw_now)
                    gcs_pkg::ST_GRABBED:
                        outs[n] = make_cmd(gcs_pkg::CMD_GRAB, shadow_cfg.grab_position);
                    gcs_pkg::ST_GRABBING:
                        outs[n] = make_cmd(gcs_pkg::CMD_GRAB, shadow_cfg.transit_position);
                    gcs_pkg::ST_RELEASING:
                        outs[n] = make_cmd(gcs_pkg::CMD_RELEASE, shadow_cfg.transit_position);
                    default:
                        outs[n] = make_cmd(gcs_pkg::CMD_RELEASE, shadow_cfg.release_position);
                endcase
                n++;
            end
            landed_now = t.is_landed;
        end
        if (!landed_now && t.rc_update && !t.rc_signal_lost)
        begin
            grab_req = $signed(t.aux_value) >= $signed(shadow_cfg.rc_threshold);
            elapsed  = t.now_us - hold_start_us;
            case (claw_now)
                gcs_pkg::ST_IDLE:
                    if (grab_req)
                    begin
                        claw_now      = gcs_pkg::ST_GRABBING;
                        hold_start_us = t.now_us;
                        outs[n] = make_cmd(gcs_pkg::CMD_GRAB, shadow_cfg.transit_position);
                        n++;
                    end
                gcs_pkg::ST_GRABBING:
                    if (elapsed >= shadow_cfg.grab_timeout_us)
                    begin
                        claw_now = gcs_pkg::ST_GRABBED;
                        outs[n]  = make_cmd(gcs_pkg::CMD_GRAB, shadow_cfg.grab_position);
                        n++;
                    end
                gcs_pkg::ST_GRABBED:
                    if (!grab_req)
                    begin
                        claw_now      = gcs_pkg::ST_RELEASING;
                        hold_start_us = t.now_us;
                        outs[n] = make_cmd(gcs_pkg::CMD_RELEASE, shadow_cfg.transit_position);
                        n++;
                    end
                gcs_pkg::ST_RELEASING:
                    if (elapsed >= shadow_cfg.release_timeout_us)
                    begin
                        claw_now = gcs_pkg::ST_IDLE;
                        outs[n]  = make_cmd(gcs_pkg::CMD_RELEASE, shadow_cfg.release_position);
                        n++;
                    end
                default:
                    ;
            endcase
        end
        if (n > 0)
            outs[n - 1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++)
            pending_cmds.push_back(outs[i]);
    endtask

    task automatic send_tick(input gcs_pkg::tick_t t);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, t};
        do @(posedge clk); while (!s_tready);
        advance_claw(t);
    endtask

    // leaves cfg_valid high; load_settings drops it after the last write
    task automatic write_reg(input gcs_pkg::cfg_index_t idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            gcs_pkg::REG_RC_THRESHOLD:    shadow_cfg.rc_threshold       = value[15:0];
            gcs_pkg::REG_GRAB_POS:        shadow_cfg.grab_position      = value[15:0];
            gcs_pkg::REG_RELEASE_POS:     shadow_cfg.release_position   = value[15:0];
            gcs_pkg::REG_TRANSIT_POS:     shadow_cfg.transit_position   = value[15:0];
            gcs_pkg::REG_LANDING_POS:     shadow_cfg.landing_position   = value[15:0];
            gcs_pkg::REG_GRAB_TIMEOUT:    shadow_cfg.grab_timeout_us    = value;
            gcs_pkg::REG_RELEASE_TIMEOUT: shadow_cfg.release_timeout_us = value;
            default:                      ;
        endcase
    endtask

    // upper half of the 16-bit registers carries junk, which must be ignored
    task automatic load_settings(input gcs_pkg::cfg_t c);
        logic [15:0] junk;
        junk = 16'($urandom);
        write_reg(gcs_pkg::REG_RC_THRESHOLD, {junk, c.rc_threshold});
        junk = 16'($urandom);
        write_reg(gcs_pkg::REG_GRAB_POS, {junk, c.grab_position});
        junk = 16'($urandom);
        write_reg(gcs_pkg::REG_RELEASE_POS, {junk, c.release_position});
        junk = 16'($urandom);
        write_reg(gcs_pkg::REG_TRANSIT_POS, {junk, c.transit_position});
        junk = 16'($urandom);
        write_reg(gcs_pkg::REG_LANDING_POS, {junk, c.landing_position});
        write_reg(gcs_pkg::REG_GRAB_TIMEOUT, c.grab_timeout_us);
        write_reg(gcs_pkg::REG_RELEASE_TIMEOUT, c.release_timeout_us);
        cfg_valid <= 1'b0;
    endtask

    // a tick may give no command, so allow for one still in flight
    task automatic wait_until_quiet();
        s_tvalid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_timeout();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return gcs_pkg::TIMEOUT_RESET;
            default: return $urandom_range(1, 250000);
        endcase
    endfunction

    function automatic gcs_pkg::cfg_t random_settings();
        gcs_pkg::cfg_t c;
        c.rc_threshold       = 16'($urandom);
        c.grab_position      = 16'($urandom);
        c.release_position   = 16'($urandom);
        c.transit_position   = 16'($urandom);
        c.landing_position   = 16'($urandom);
        c.grab_timeout_us    = pick_timeout();
        c.release_timeout_us = pick_timeout();
        return c;
    endfunction

    // mostly a 20 Hz tick stream with aux close to the threshold
    function automatic gcs_pkg::tick_t random_tick();
        gcs_pkg::tick_t t;
        int             level;
        t = '0;
        if ($urandom_range(0, 11) == 0)
        begin
            t.land_update = 1'b1;
            t.is_landed   = ($urandom_range(0, 3) != 0) ? !landed_now : landed_now;
        end
        else
            t.is_landed = 1'($urandom_range(0, 1));
        t.rc_update      = $urandom_range(0, 7) != 0;
        t.rc_signal_lost = $urandom_range(0, 9) == 0;
        if ($urandom_range(0, 3) == 0)
            t.aux_value = 16'($urandom);
        else
        begin
            level = int'($signed(shadow_cfg.rc_threshold)) + int'($urandom_range(0, 64)) - 32;
            if (level > 32767)
                level = 32767;
            if (level < -32768)
                level = -32768;
            t.aux_value = level[15:0];
        end
        case ($urandom_range(0, 19))
            0:       ;
            1:       clock_us = $urandom;
            default: clock_us = clock_us + $urandom_range(10000, 90000);
        endcase
        t.now_us = clock_us;
        return t;
    endfunction

    task automatic test_reset_defaults();
        send_tick(tick_of(1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, 32'd100));
        send_tick(tick_of(1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, 32'd1000099));
        send_tick(tick_of(1'b0, 1'b0, 1'b1, 1'b1, 16'h7FFF, 32'd2000000));
        send_tick(tick_of(1'b0, 1'b0, 1'b0, 1'b0, 16'h7FFF, 32'd2000000));
        send_tick(tick_of(1'b0, 1'b0, 1'b1, 1'b0, 16'hFFFF, 32'd1000100));
    endtask

    task automatic test_register_extremes();
        gcs_pkg::cfg_t c;
        c.rc_threshold       = 16'h7FFF;
        c.grab_position      = 16'h7FFF;
        c.release_position   = 16'h8000;
        c.transit_position   = 16'h5555;
        c.landing_position   = 16'hAAAA;
        c.grab_timeout_us    = 32'd0;
        c.release_timeout_us = 32'hFFFF_FFFF;
        wait_until_quiet();
        load_settings(c);
        send_tick(tick_of(1'b0, 1'b0, 1'b1, 1'b0, 16'h7FFE, 32'h0000_0000));
        // elapsed one short of the timeout, then exactly at it across the wrap
        send_tick(tick_of(1'b0, 1'b0, 1'b1, 1'b0, 16'h7FFE, 32'hFFFF_FFFE));
        send_tick(tick_of(1'b0, 1'b0, 1'b1, 1'b0, 16'h7FFE, 32'hFFFF_FFFF));
        send_tick(tick_of(1'b0, 1'b0, 1'b1, 1'b0, 16'h7FFF, 32'd5));
        send_tick(tick_of(1'b0, 1'b0, 1'b1, 1'b1, 16'h7FFF, 32'd5));
        // zero grab timeout: locks on the next good sample
        send_tick(tick_of(1'b0, 1'b0, 1'b1, 1'b0, 16'h8000, 32'd5));
    endtask

    task automatic test_landing_cycle();
        send_tick(tick_of(1'b1, 1'b1, 1'b1, 1'b0, 16'h8000, 32'd100));
        send_tick(tick_of(1'b1, 1'b1, 1'b0, 1'b0, 16'h0000, 32'd200));
        send_tick(tick_of(1'b0, 1'b0, 1'b1, 1'b0, 16'h8000, 32'd300));
        // takeoff restores grabbed, then the same tick starts a release
        send_tick(tick_of(1'b1, 1'b0, 1'b1, 1'b0, 16'h8000, 32'd400));
        send_tick(tick_of(1'b1, 1'b1, 1'b0, 1'b0, 16'h0000, 32'd500));
        send_tick(tick_of(1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, 32'd600));
        send_tick(tick_of(1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, 32'd399));
        send_tick(tick_of(1'b1, 1'b1, 1'b0, 1'b0, 16'h0000, 32'd1000));
        send_tick(tick_of(1'b1, 1'b0, 1'b1, 1'b0, 16'h7FFF, 32'd1100));
        send_tick(tick_of(1'b1, 1'b1, 1'b0, 1'b0, 16'h0000, 32'd1200));
        send_tick(tick_of(1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, 32'd1300));
        send_tick(tick_of(1'b0, 1'b1, 1'b1, 1'b0, 16'h0000, 32'd1400));
        send_tick(tick_of(1'b1, 1'b0, 1'b1, 1'b0, 16'h0000, 32'd1500));
    endtask

    task automatic test_output_backpressure();
        gcs_pkg::cfg_t c;
        c                    = shadow_cfg;
        c.rc_threshold       = 16'h0000;
        c.grab_timeout_us    = 32'd0;
        c.release_timeout_us = 32'd0;
        wait_until_quiet();
        load_settings(c);
        tx_max_gap     = 0;
        rx_hold_cycles = 150;
        for (int i = 0; i < 24; i++)
            send_tick(tick_of(i == 0, 1'b0, 1'b1, 1'b0,
                              (i % 4 < 2) ? 16'h4000 : 16'hC000, clock_us + i));
        wait_until_quiet();
        tx_max_gap = 13;
    endtask

    task automatic test_random_traffic();
        gcs_pkg::cfg_t c;
        for (int phase = 0; phase < 6; phase++)
        begin
            c = random_settings();
            case (phase)
                0:
                begin
                    tx_max_gap = 0;
                    rx_max_gap = 0;
                end
                2:
                begin
                    tx_max_gap = 0;
                    rx_max_gap = 13;
                end
                3:
                begin
                    tx_max_gap = 13;
                    rx_max_gap = 0;
                end
                default:
                begin
                    tx_max_gap = 13;
                    rx_max_gap = 13;
                end
            endcase
            if (phase == 4)
            begin
                c.rc_threshold       = 16'h8000;
                c.grab_position      = 16'h8000;
                c.release_position   = 16'h8000;
                c.transit_position   = 16'h8000;
                c.landing_position   = 16'h8000;
                c.grab_timeout_us    = 32'd0;
                c.release_timeout_us = 32'd0;
            end
            else if (phase == 5)
            begin
                c.rc_threshold       = 16'h7FFF;
                c.grab_position      = 16'h7FFF;
                c.release_position   = 16'h7FFF;
                c.transit_position   = 16'h7FFF;
                c.landing_position   = 16'h7FFF;
                c.grab_timeout_us    = 32'hFFFF_FFFF;
                c.release_timeout_us = 32'hFFFF_FFFF;
            end
            wait_until_quiet();
            load_settings(c);
            for (int i = 0; i < PHASE_TICKS; i++)
            begin
                send_tick(random_tick());
                if ($urandom_range(0, 63) == 0)
                    wait_until_quiet();
            end
        end
    endtask

    initial
    begin : main_sequence
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= gcs_pkg::REG_RC_THRESHOLD;
        cfg_data  <= '0;
        claw_now      = gcs_pkg::ST_IDLE;
        claw_saved    = gcs_pkg::ST_IDLE;
        landed_now    = 1'b0;
        hold_start_us = '0;
        shadow_cfg.rc_threshold       = '0;
        shadow_cfg.grab_position      = '0;
        shadow_cfg.release_position   = '0;
        shadow_cfg.transit_position   = '0;
        shadow_cfg.landing_position   = '0;
        shadow_cfg.grab_timeout_us    = gcs_pkg::TIMEOUT_RESET;
        shadow_cfg.release_timeout_us = gcs_pkg::TIMEOUT_RESET;
        clock_us = 32'd3000000;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_register_extremes();
        test_landing_cycle();
        test_output_backpressure();
        test_random_traffic();
        wait_until_quiet();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // result sink: random stalls per item, plus the long hold when asked
    initial
    begin : result_sink
        int stall;
        m_tready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
            end
            stall = $urandom_range(0, rx_max_gap);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin : command_check
        gcs_pkg::result_t got;
        gcs_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tlast, m_tdata[16:0]};
            if (pending_cmds.size() == 0)
            begin
                $display("%0t: unexpected command, expected none, actual %h", $time, got);
                mismatches++;
            end
            else
            begin
                want = pending_cmds.pop_front();
                if (got.gripper_command !== want.gripper_command)
                begin
                    $display("%0t: gripper_command expected %0d actual %0d", $time,
                             want.gripper_command, got.gripper_command);
                    mismatches++;
                end
                if (got.servo_position !== want.servo_position)
                begin
                    $display("%0t: servo_position expected %h actual %h", $time,
                             want.servo_position, got.servo_position);
                    mismatches++;
                end
                if (got.last_of_run !== want.last_of_run)
                begin
                    $display("%0t: last_of_run expected %0d actual %0d", $time,
                             want.last_of_run, got.last_of_run);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule
